### design/ffha_pkg.sv
// Shared types, codes and state encoding for the first-fit heap allocator.
package ffha_pkg;

	localparam int ADDR_W = 20;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADFREE = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] REG_HEAP_SIZE = 2'd0;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] request_size;
		logic [ADDR_W-1:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] data_offset;
	} rsp_t;

	// One block table entry: free mark and header offset.
	typedef struct packed {
		logic              free;
		logic [ADDR_W-1:0] start;
	} blk_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_req;
		logic init_pool;
		logic scan_start;
		logic scan_step;
		logic decide;
		logic shift_up_step;
		logic shift_dn_step;
		logic finish_ok;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_hit;
		logic scan_end;
		logic need_up;
		logic need_dn;
		logic shift_last;
	} dp_sts_t;

endpackage

### design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: APB register, channels, controller, datapath.
//
// Usage: requests enter on req_valid/req_ready with a req_t payload
// (command 0 allocate, 1 free). Each request gives one rsp_t transaction
// on rsp_valid/rsp_ready: a status and, for a good allocate, the payload
// offset. One request is in flight at a time.
// Sequence: after acceptance the table is scanned up to the matching
// block (to the end when nothing matches), a split inserts a table entry,
// and a free runs one shift pass per merge (a double merge runs twice)
// before rsp_valid rises. The one-entry-per-cycle table scan and shift
// set the rate; req_ready returns in idle once the previous result is
// taken or leaving.
// Reset sets heap_size to 65536 and the table to one free block at the
// pool header, written in the init state before req_ready rises; a
// heap_size write re-creates the table the same way.
// A stalled receiver holds the result in the output register; the next
// request is not accepted until that result is taken.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int MAX_BLOCKS        = 64,
	parameter int NODE_BYTES        = 32,
	parameter int POOL_HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);

	logic [ADDR_W-1:0] heap_size_q;
	logic              cfg_wr;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr == REG_HEAP_SIZE;
	assign prdata = (paddr == REG_HEAP_SIZE) ? 32'(heap_size_q) : '0;

	// heap_size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) heap_size_q <= ADDR_W'(65536);
		else if (cfg_wr) heap_size_q <= pwdata[ADDR_W-1:0];
	end

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffha_dp #(
		.MAX_BLOCKS        (MAX_BLOCKS),
		.NODE_BYTES        (NODE_BYTES),
		.POOL_HEADER_BYTES (POOL_HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.heap_size (heap_size_q),
		.cmd       (cmd),
		.req       (req),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

### design/ffha_ctrl.sv
// Controller state machine for the allocator: sequences scan, decision and shifts.
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_take;

	// New transaction only once the previous result is gone or leaving now
	assign in_take = (state_q == S_IDLE) && in_valid && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:     state_d = S_IDLE;
			S_IDLE:     if (in_take) state_d = S_SCAN;
			S_SCAN:     if (sts.scan_hit || sts.scan_end) state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.need_up) state_d = S_SHIFT_UP;
				else if (sts.need_dn) state_d = S_SHIFT_DN;
				else state_d = S_DONE;
			end
			S_SHIFT_UP: if (sts.shift_last) state_d = S_DONE;
			S_SHIFT_DN: begin
				if (sts.shift_last && sts.need_dn) state_d = S_SHIFT_DN;
				else if (sts.shift_last) state_d = S_DONE;
			end
			S_DONE:     if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
		if (cfg_wr) state_d = S_INIT;
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_INIT:     cmd.init_pool = 1'b1;
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.load_req = in_take;
				cmd.scan_start = in_take;
			end
			S_SCAN:     cmd.scan_step = 1'b1;
			S_DECIDE:   cmd.decide = 1'b1;
			S_SHIFT_UP: cmd.shift_up_step = 1'b1;
			S_SHIFT_DN: cmd.shift_dn_step = 1'b1;
			S_DONE:     cmd.finish_ok = !out_valid_q || out_ready;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish_ok) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/ffha_dp.sv
// Datapath: block table, scan index, shift engine and result register.
module ffha_dp
	import ffha_pkg::*;
#(
	parameter int MAX_BLOCKS        = 64,
	parameter int NODE_BYTES        = 32,
	parameter int POOL_HEADER_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] heap_size,
	input  dp_cmd_t           cmd,
	input  req_t              req,
	output dp_sts_t           sts,
	output rsp_t              rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = ADDR_W + 2;

	// Table memory: two registered reads and one write per cycle.
	// Entries at or above count_q are never used, so no clearing pass.
	blk_t              mem_q [MAX_BLOCKS];
	blk_t              rd0_q, rd1_q;
	logic [IW-1:0]     ra0, ra1, wa;
	blk_t              wd;
	logic              we;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     shift_q;
	logic [CW-1:0]     target_q;
	logic              found_q;
	logic              dn_pend_q;
	logic              prev_free_q;
	req_t              req_q;
	rsp_t              rsp_q;

	logic [SW-1:0]     cur_s, cur_e, need;
	logic              cur_last;
	logic              hit;
	logic              merge_next, merge_prev, free_ok, alloc_ok;

	// rd0_q holds entry idx_q, rd1_q entry idx_q + 1 while scanning
	assign cur_last = (idx_q + CW'(1)) >= count_q;
	assign cur_s    = SW'(rd0_q.start);
	assign cur_e    = cur_last ? SW'(heap_size) : SW'(rd1_q.start);
	assign need     = SW'(req_q.request_size) + SW'(2 * NODE_BYTES);

	// Match test of the current entry.
	always_comb begin
		if (req_q.command == CMD_ALLOC)
			hit = rd0_q.free && (cur_s + need <= cur_e);
		else
			hit = (cur_s + SW'(NODE_BYTES)) == SW'(req_q.free_offset);
	end

	assign merge_next = !cur_last && rd1_q.free;
	assign merge_prev = idx_q != '0 && prev_free_q;
	assign free_ok    = req_q.command == CMD_FREE && found_q && !rd0_q.free;
	assign alloc_ok   = req_q.command == CMD_ALLOC && found_q
		&& count_q < CW'(MAX_BLOCKS);

	assign sts.scan_hit   = hit && idx_q < count_q;
	assign sts.scan_end   = idx_q >= count_q || (idx_q + CW'(1)) >= count_q;
	assign sts.need_up    = alloc_ok;
	// Before a merge: any merge; during one: the previous neighbor still follows
	assign sts.need_dn    = dn_pend_q ? (target_q == idx_q && merge_prev)
		: (free_ok && (merge_next || merge_prev));
	assign sts.shift_last = dn_pend_q ? ((shift_q + CW'(1)) >= count_q)
		: (shift_q <= target_q);
	assign rsp = rsp_q;

	// Read addresses: fetch what the next cycle works on
	always_comb begin
		ra0 = IW'(idx_q);
		ra1 = IW'(idx_q + CW'(1));
		if (cmd.scan_start) begin
			ra0 = '0;
			ra1 = IW'(1);
		end else if (cmd.scan_step && !sts.scan_hit) begin
			ra0 = IW'(idx_q + CW'(1));
			ra1 = IW'(idx_q + CW'(2));
		end else if (cmd.decide) begin
			if (alloc_ok) ra0 = IW'(count_q - CW'(1));
			else if (merge_next) ra0 = IW'(idx_q + CW'(2));
			else ra0 = IW'(idx_q + CW'(1));
		end else if (cmd.shift_up_step && shift_q > target_q) begin
			ra0 = IW'(shift_q - CW'(2));
		end else if (cmd.shift_dn_step) begin
			if ((shift_q + CW'(1)) < count_q) ra0 = IW'(shift_q + CW'(2));
			else ra0 = IW'(idx_q + CW'(1));
		end
	end

	// Write port: init, mark, one shifted entry or the split header
	always_comb begin
		we = 1'b0;
		wa = IW'(idx_q);
		wd = rd0_q;
		if (cmd.init_pool) begin
			we       = 1'b1;
			wa       = '0;
			wd.free  = 1'b1;
			wd.start = ADDR_W'(POOL_HEADER_BYTES);
		end else if (cmd.decide && (alloc_ok || free_ok)) begin
			we       = 1'b1;
			wd.free  = free_ok;
			wd.start = rd0_q.start;
		end else if (cmd.shift_up_step) begin
			we = 1'b1;
			if (shift_q > target_q) begin
				wa = IW'(shift_q);
			end else begin
				wa       = IW'(target_q);
				wd.free  = 1'b1;
				wd.start = rsp_q.data_offset + req_q.request_size;
			end
		end else if (cmd.shift_dn_step && (shift_q + CW'(1)) < count_q) begin
			we = 1'b1;
			wa = IW'(shift_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd0_q <= mem_q[ra0];
		rd1_q <= mem_q[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			idx_q       <= '0;
			found_q     <= 1'b0;
			dn_pend_q   <= 1'b0;
			prev_free_q <= 1'b0;
			shift_q     <= '0;
			target_q    <= '0;
			req_q       <= '0;
			rsp_q       <= '0;
		end else begin
			if (cmd.init_pool) count_q <= CW'(1);
			if (cmd.load_req) begin
				req_q   <= req;
				found_q <= 1'b0;
				dn_pend_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				idx_q       <= '0;
				prev_free_q <= 1'b0;
			end
			// One entry per cycle
			if (cmd.scan_step) begin
				if (sts.scan_hit) found_q <= 1'b1;
				else begin
					idx_q       <= idx_q + CW'(1);
					prev_free_q <= rd0_q.free;
				end
			end
			// Resolve the request once the scan has stopped
			if (cmd.decide) begin
				rsp_q.data_offset <= '0;
				rsp_q.status <= ST_OK;
				if (req_q.command == CMD_ALLOC) begin
					if (!found_q) rsp_q.status <= ST_NOFIT;
					else if (count_q >= CW'(MAX_BLOCKS)) rsp_q.status <= ST_FULL;
					else begin
						rsp_q.data_offset <= ADDR_W'(cur_s + SW'(NODE_BYTES));
						shift_q  <= count_q;
						target_q <= idx_q + CW'(1);
					end
				end else if (!free_ok) begin
					rsp_q.status <= ST_BADFREE;
				end else begin
					// Pick which entry to remove first: next, else self
					if (merge_next) begin
						dn_pend_q <= 1'b1;
						shift_q   <= idx_q + CW'(1);
						target_q  <= idx_q;
					end else if (merge_prev) begin
						dn_pend_q <= 1'b1;
						shift_q   <= idx_q;
						target_q  <= idx_q - CW'(1);
					end
				end
			end
			// Insert: move entries up one per cycle, then write the split
			if (cmd.shift_up_step) begin
				if (shift_q > target_q) shift_q <= shift_q - CW'(1);
				else count_q <= count_q + CW'(1);
			end
			// Remove: move entries down one per cycle
			if (cmd.shift_dn_step) begin
				if ((shift_q + CW'(1)) < count_q) begin
					shift_q <= shift_q + CW'(1);
				end else begin
					count_q <= count_q - CW'(1);
					// Second merge: previous neighbor absorbs released block
					if (target_q == idx_q && merge_prev) begin
						shift_q  <= idx_q;
						target_q <= idx_q - CW'(1);
					end else begin
						dn_pend_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule
